// File: hw/rtl/ptf_pkg.sv
// ptf_pkg: shared constants, types and helper functions for the floor projection block
// no dependencies; imported by every module of the block

package ptf_pkg;

    localparam int DIM_W    = 13;
    localparam int PIX_W    = 12;
    localparam int ANG_W    = 18;
    localparam int MAX_SIDE = 4096;
    localparam int STAGES   = 28;

    // cos/sin width, cordic angle width
    localparam int CS_W = 34;
    localparam int Z_W  = 33;

    localparam int PI_Q15      = 102944;
    localparam int HALF_PI_Q15 = 51472;
    localparam int GAIN_Q30    = 652032874;

    localparam logic [30:0] RAY_MAX = 31'h7FFF_FFFF;

    localparam logic [31:0] ATAN_TAB [STAGES] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd7
    };

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CAM_TILT      = 3'd2,
        REG_CAM_PAN       = 3'd3,
        REG_CAM_ELEVATION = 3'd4,
        REG_FOCAL_LEN     = 3'd5,
        REG_SENSOR_WIDTH  = 3'd6,
        REG_SENSOR_HEIGHT = 3'd7
    } cfg_reg_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -36'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ptf_div_cell.sv
// ptf_div_cell: one restoring division step with a registered output
// uses ptf_pkg; instantiated in a row by ptf_div_chain

module ptf_div_cell
    import ptf_pkg::*;
#(
    parameter int DW = 13,
    parameter int QW = 17,
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_dvs,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_dvs,
    output logic [TW-1:0] out_tag
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next, dvs_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [TW-1:0] tag_reg;
    logic [DW:0]   trial, diff;
    logic          take;

    assign trial    = {in_rem, in_quo[QW-1]};
    assign diff     = trial - {1'b0, in_dvs};
    assign take     = (trial >= {1'b0, in_dvs});
    assign rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
    assign quo_next = {in_quo[QW-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= in_dvs;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dvs   = dvs_reg;
    assign out_tag   = tag_reg;

endmodule

// File: hw/rtl/ptf_div_chain.sv
// ptf_div_chain: row of QW division cells, one quotient bit per cell and cycle
// while en is high; uses ptf_pkg and ptf_div_cell

module ptf_div_chain
    import ptf_pkg::*;
#(
    parameter int DW = 13,
    parameter int QW = 17,
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_dvs,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);

    logic          valid_w [QW+1];
    logic [DW-1:0] rem_w   [QW+1];
    logic [QW-1:0] quo_w   [QW+1];
    logic [DW-1:0] dvs_w   [QW+1];
    logic [TW-1:0] tag_w   [QW+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_rem;
    assign quo_w[0]   = in_quo;
    assign dvs_w[0]   = in_dvs;
    assign tag_w[0]   = in_tag;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        ptf_div_cell #(.DW(DW), .QW(QW), .TW(TW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[i]),
            .in_rem    (rem_w[i]),
            .in_quo    (quo_w[i]),
            .in_dvs    (dvs_w[i]),
            .in_tag    (tag_w[i]),
            .out_valid (valid_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_quo   (quo_w[i+1]),
            .out_dvs   (dvs_w[i+1]),
            .out_tag   (tag_w[i+1])
        );
    end

    assign out_valid = valid_w[QW];
    assign out_rem   = rem_w[QW];
    assign out_quo   = quo_w[QW];
    assign out_tag   = tag_w[QW];

endmodule

// File: hw/rtl/ptf_cordic_cell.sv
// ptf_cordic_cell: one cordic micro-rotation, vectoring or rotation mode, registered
// uses ptf_pkg for the arctangent table

module ptf_cordic_cell
    import ptf_pkg::*;
#(
    parameter int W      = 34,
    parameter int ZW     = 33,
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0,
    parameter int TW     = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  in_x,
    input  logic signed [W-1:0]  in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic [TW-1:0]        in_tag,
    output logic                 out_valid,
    output logic signed [W-1:0]  out_x,
    output logic signed [W-1:0]  out_y,
    output logic signed [ZW-1:0] out_z,
    output logic [TW-1:0]        out_tag
);

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next, step;
    logic [TW-1:0]        tag_reg;
    logic                 up;

    assign xs   = in_x >>> STAGE;
    assign ys   = in_y >>> STAGE;
    assign step = ZW'(ATAN_TAB[STAGE]);
    // vectoring drives y to zero, rotation drives z to zero
    assign up   = VECTOR ? (!in_y[W-1] && (in_y != '0)) : in_z[ZW-1];

    assign x_next = up ? (in_x + ys) : (in_x - ys);
    assign y_next = up ? (in_y - xs) : (in_y + xs);
    assign z_next = up ? (in_z + step) : (in_z - step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_tag   = tag_reg;

endmodule

// File: hw/rtl/ptf_lane.sv
// ptf_lane: pixel index to camera-relative angle, fold into +-pi/2, then cos and sin
// uses ptf_pkg, ptf_div_chain and ptf_cordic_cell; one lane for tilt, one for pan

module ptf_lane
    import ptf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [PIX_W-1:0]        idx,
    input  logic [DIM_W-1:0]        side,
    input  logic [31:0]             sensor,
    input  logic [31:0]             focal,
    input  logic signed [ANG_W-1:0] cam_ang,
    output logic                    out_valid,
    output logic signed [CS_W-1:0]  out_cos,
    output logic signed [CS_W-1:0]  out_sin,
    output logic                    out_below
);

    localparam int AT_W = 58;

    // normalised position: idx * 2^17 / side
    logic             pd_valid;
    logic [DIM_W-1:0] pd_rem;
    logic [16:0]      pd_quo;
    logic             pd_tag;

    ptf_div_chain #(.DW(DIM_W), .QW(17), .TW(1)) u_pix_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_rem    (DIM_W'(idx)),
        .in_quo    ('0),
        .in_dvs    (side),
        .in_tag    (1'b0),
        .out_valid (pd_valid),
        .out_rem   (pd_rem),
        .out_quo   (pd_quo),
        .out_tag   (pd_tag)
    );

    // sensor * |s|
    logic        b_valid_reg, b_neg_reg, b_neg_next;
    logic [48:0] b_num_reg, b_num_next;
    logic [16:0] b_mag;

    assign b_neg_next = !pd_quo[16];
    assign b_mag      = pd_quo[16] ? {1'b0, pd_quo[15:0]} : (17'h1_0000 - pd_quo);
    assign b_num_next = 49'(sensor) * 49'(b_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= pd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_num_reg <= b_num_next;
            b_neg_reg <= b_neg_next;
        end
    end

    // argument: num / (2 * focal), saturated
    logic [32:0] c_dvs;
    logic        c_sat, c_zero;
    logic        ad_valid;
    logic [32:0] ad_rem;
    logic [46:0] ad_quo;
    logic [2:0]  ad_tag;

    assign c_dvs  = {focal, 1'b0};
    assign c_sat  = (33'(b_num_reg[48:47]) >= c_dvs);
    assign c_zero = (b_num_reg == '0);

    ptf_div_chain #(.DW(33), .QW(47), .TW(3)) u_arg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_rem    (33'(b_num_reg[48:47])),
        .in_quo    (b_num_reg[46:0]),
        .in_dvs    (c_dvs),
        .in_tag    ({b_neg_reg, c_sat, c_zero}),
        .out_valid (ad_valid),
        .out_rem   (ad_rem),
        .out_quo   (ad_quo),
        .out_tag   (ad_tag)
    );

    // signed argument as cordic y input
    logic                   d_valid_reg;
    logic signed [AT_W-1:0] d_y_reg, d_y_next;
    logic [47:0]            d_q;

    assign d_q      = ad_tag[0] ? 48'd0 : (ad_tag[1] ? 48'h8000_0000_0000 : {1'b0, ad_quo});
    assign d_y_next = ad_tag[2] ? -$signed({2'b00, d_q, 8'h00}) : $signed({2'b00, d_q, 8'h00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= ad_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_y_reg <= d_y_next;
        end
    end

    // arctangent
    logic                   at_valid [STAGES+1];
    logic signed [AT_W-1:0] at_x     [STAGES+1];
    logic signed [AT_W-1:0] at_y     [STAGES+1];
    logic signed [Z_W-1:0]  at_z     [STAGES+1];
    logic                   at_tag   [STAGES+1];

    assign at_valid[0] = d_valid_reg;
    assign at_x[0]     = AT_W'(32'sd16777216);
    assign at_y[0]     = d_y_reg;
    assign at_z[0]     = '0;
    assign at_tag[0]   = 1'b0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_atan
        ptf_cordic_cell #(.W(AT_W), .ZW(Z_W), .STAGE(i), .VECTOR(1'b1), .TW(1)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (at_valid[i]),
            .in_x      (at_x[i]),
            .in_y      (at_y[i]),
            .in_z      (at_z[i]),
            .in_tag    (at_tag[i]),
            .out_valid (at_valid[i+1]),
            .out_x     (at_x[i+1]),
            .out_y     (at_y[i+1]),
            .out_z     (at_z[i+1]),
            .out_tag   (at_tag[i+1])
        );
    end

    // round to q15, add camera angle, measure the excess beyond +-pi/2
    logic                  f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic signed [17:0]    f1_pix_reg;
    logic signed [Z_W-1:0] f1_round;
    logic signed [18:0]    f2_theta_reg, f2_theta_next;
    logic signed [18:0]    f3_theta_reg;
    logic                  f3_over_reg, f3_over_next, f3_under_reg, f3_under_next;
    logic [17:0]           f3_exc_reg, f3_exc_next;
    logic signed [18:0]    f3_up, f3_dn;

    assign f1_round      = at_z[STAGES] + Z_W'(16384);
    assign f2_theta_next = 19'(cam_ang) + 19'(f1_pix_reg);
    assign f3_over_next  = (f2_theta_reg > 19'sd51472);
    assign f3_under_next = (f2_theta_reg < -19'sd51472);
    assign f3_up         = f2_theta_reg - 19'sd51473;
    assign f3_dn         = -19'sd51473 - f2_theta_reg;
    assign f3_exc_next   = f3_over_next ? f3_up[17:0] : f3_dn[17:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= at_valid[STAGES];
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pix_reg   <= f1_round[Z_W-1:15];
            f2_theta_reg <= f2_theta_next;
            f3_theta_reg <= f2_theta_reg;
            f3_over_reg  <= f3_over_next;
            f3_under_reg <= f3_under_next;
            f3_exc_reg   <= f3_exc_next;
        end
    end

    // fold by pi: the excess is below three times pi, so two compares give quotient and rest
    logic        fd_valid_reg, fd_odd_reg;
    logic [16:0] fd_rem_reg;
    logic [21:0] fd_tag_reg;
    logic        g_ge1, g_ge2;
    logic [16:0] g_rem;

    assign g_ge2 = (f3_exc_reg >= 18'(2 * PI_Q15));
    assign g_ge1 = (f3_exc_reg >= 18'(PI_Q15));
    assign g_rem = g_ge2 ? 17'(f3_exc_reg - 18'(2 * PI_Q15))
                 : (g_ge1 ? 17'(f3_exc_reg - 18'(PI_Q15)) : 17'(f3_exc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fd_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fd_rem_reg <= g_rem;
            fd_odd_reg <= g_ge1 && !g_ge2;
            fd_tag_reg <= {f3_theta_reg[18], f3_over_reg, f3_under_reg, f3_theta_reg};
        end
    end

    logic                  h_valid_reg, h_flip_reg, h_flip_next, h_below_reg;
    logic signed [Z_W-1:0] h_z_reg;
    logic signed [18:0]    h_ang, h_r;

    assign h_r  = $signed({2'b00, fd_rem_reg});
    assign h_flip_next = (fd_tag_reg[20] || fd_tag_reg[19]) && !fd_odd_reg;

    always_comb
    begin
        if (fd_tag_reg[20])
        begin
            h_ang = h_r - 19'sd51471;
        end
        else if (fd_tag_reg[19])
        begin
            h_ang = 19'sd51471 - h_r;
        end
        else
        begin
            h_ang = $signed(fd_tag_reg[18:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h_valid_reg <= fd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_z_reg     <= $signed({h_ang[17:0], 15'h0000});
            h_flip_reg  <= h_flip_next;
            h_below_reg <= fd_tag_reg[21];
        end
    end

    // cos and sin
    logic                   sc_valid [STAGES+1];
    logic signed [CS_W-1:0] sc_x     [STAGES+1];
    logic signed [CS_W-1:0] sc_y     [STAGES+1];
    logic signed [Z_W-1:0]  sc_z     [STAGES+1];
    logic [1:0]             sc_tag   [STAGES+1];

    assign sc_valid[0] = h_valid_reg;
    assign sc_x[0]     = CS_W'(GAIN_Q30);
    assign sc_y[0]     = '0;
    assign sc_z[0]     = h_z_reg;
    assign sc_tag[0]   = {h_below_reg, h_flip_reg};

    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        ptf_cordic_cell #(.W(CS_W), .ZW(Z_W), .STAGE(i), .VECTOR(1'b0), .TW(2)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sc_valid[i]),
            .in_x      (sc_x[i]),
            .in_y      (sc_y[i]),
            .in_z      (sc_z[i]),
            .in_tag    (sc_tag[i]),
            .out_valid (sc_valid[i+1]),
            .out_x     (sc_x[i+1]),
            .out_y     (sc_y[i+1]),
            .out_z     (sc_z[i+1]),
            .out_tag   (sc_tag[i+1])
        );
    end

    logic                   j_valid_reg, j_below_reg;
    logic signed [CS_W-1:0] j_cos_reg, j_cos_next, j_sin_reg, j_sin_next;

    assign j_cos_next = sc_tag[STAGES][0] ? -sc_x[STAGES] : sc_x[STAGES];
    assign j_sin_next = sc_tag[STAGES][0] ? -sc_y[STAGES] : sc_y[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            j_valid_reg <= sc_valid[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_cos_reg   <= j_cos_next;
            j_sin_reg   <= j_sin_next;
            j_below_reg <= sc_tag[STAGES][1];
        end
    end

    assign out_valid = j_valid_reg;
    assign out_cos   = j_cos_reg;
    assign out_sin   = j_sin_reg;
    assign out_below = j_below_reg;

endmodule

// File: hw/rtl/pixel_to_floor_projection_top.sv
// pixel_to_floor_projection_top: configuration registers, two angle lanes, ray and output stages
// uses ptf_pkg, ptf_lane and ptf_div_chain

// Projects mask pixels onto the floor through a pinhole camera model. One pixel
// transfer is taken every clock unless the output is held; a result passes
// through the fully pipelined cell rows: 17-bit and 47-bit dividers, two
// 28-stage cordic rows, a one-stage fold by pi per lane, then a 31-bit ray
// divider. Pixels with the mask clear, outside the frame, below the horizon or
// with a negative ray give no result. When the output is held, the whole pipeline
// holds with it. Configuration writes must only happen with no pixel in flight.

module pixel_to_floor_projection_top
    import ptf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   pixel_col,
    input  logic [PIX_W-1:0]   pixel_row,
    input  logic               mask_bit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] floor_dx,
    output logic signed [31:0] floor_dy
);

    logic [DIM_W-1:0]        image_width_reg, image_height_reg;
    logic signed [ANG_W-1:0] cam_tilt_reg, cam_pan_reg;
    logic [31:0]             cam_elevation_reg, focal_len_reg;
    logic [31:0]             sensor_width_reg, sensor_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 13'd640;
            image_height_reg  <= 13'd480;
            cam_tilt_reg      <= '0;
            cam_pan_reg       <= '0;
            cam_elevation_reg <= 32'h0001_0000;
            focal_len_reg     <= 32'h0001_0000;
            sensor_width_reg  <= 32'h0001_0000;
            sensor_height_reg <= 32'h0001_0000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_W-1:0];
                REG_CAM_TILT:      cam_tilt_reg      <= cfg_data[ANG_W-1:0];
                REG_CAM_PAN:       cam_pan_reg       <= cfg_data[ANG_W-1:0];
                REG_CAM_ELEVATION: cam_elevation_reg <= cfg_data;
                REG_FOCAL_LEN:     focal_len_reg     <= cfg_data;
                REG_SENSOR_WIDTH:  sensor_width_reg  <= cfg_data;
                REG_SENSOR_HEIGHT: sensor_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    logic             en, keep, out_valid_reg;
    logic [DIM_W-1:0] dim_w, dim_h;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign dim_w    = (image_width_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : image_width_reg;
    assign dim_h    = (image_height_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : image_height_reg;
    assign keep     = in_valid && en && mask_bit && (dim_w != '0) && (dim_h != '0)
                      && (DIM_W'(pixel_col) < dim_w) && (DIM_W'(pixel_row) < dim_h);

    logic                   t_valid, t_below, p_valid, p_below;
    logic signed [CS_W-1:0] t_cos, t_sin, p_cos, p_sin;

    ptf_lane u_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (keep),
        .idx       (pixel_row),
        .side      (dim_h),
        .sensor    (sensor_height_reg),
        .focal     (focal_len_reg),
        .cam_ang   (cam_tilt_reg),
        .out_valid (t_valid),
        .out_cos   (t_cos),
        .out_sin   (t_sin),
        .out_below (t_below)
    );

    ptf_lane u_pan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (keep),
        .idx       (pixel_col),
        .side      (dim_w),
        .sensor    (sensor_width_reg),
        .focal     (focal_len_reg),
        .cam_ang   (cam_pan_reg),
        .out_valid (p_valid),
        .out_cos   (p_cos),
        .out_sin   (p_sin),
        .out_below (p_below)
    );

    // elevation * |cos tilt|
    logic                   k_valid_reg, k_stz_reg, k_cneg_reg, k_sneg_reg, k_below_reg;
    logic [64:0]            k_num_reg, k_num_next;
    logic [32:0]            k_as_reg, k_as_next, k_ac;
    logic signed [CS_W-1:0] k_cp_reg, k_sp_reg, k_cabs, k_sabs;

    assign k_cabs     = t_cos[CS_W-1] ? -t_cos : t_cos;
    assign k_sabs     = t_sin[CS_W-1] ? -t_sin : t_sin;
    assign k_ac       = k_cabs[32:0];
    assign k_as_next  = k_sabs[32:0];
    assign k_num_next = 65'(cam_elevation_reg) * 65'(k_ac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k_valid_reg <= t_valid && p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_num_reg   <= k_num_next;
            k_as_reg    <= k_as_next;
            k_stz_reg   <= (t_sin == '0);
            k_cneg_reg  <= t_cos[CS_W-1];
            k_sneg_reg  <= t_sin[CS_W-1];
            k_below_reg <= t_below || p_below && 1'b0;
            k_cp_reg    <= p_cos;
            k_sp_reg    <= p_sin;
        end
    end

    // ray = num / |sin tilt|
    logic        l_sat;
    logic        rd_valid;
    logic [32:0] rd_rem;
    logic [30:0] rd_quo;
    logic [72:0] rd_tag;

    assign l_sat = (k_num_reg[64:31] >= {1'b0, k_as_reg});

    ptf_div_chain #(.DW(33), .QW(31), .TW(73)) u_ray_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (k_valid_reg),
        .in_rem    (k_num_reg[63:31]),
        .in_quo    (k_num_reg[30:0]),
        .in_dvs    (k_as_reg),
        .in_tag    ({l_sat, k_stz_reg, k_cneg_reg, k_sneg_reg, k_below_reg,
                     k_cp_reg, k_sp_reg}),
        .out_valid (rd_valid),
        .out_rem   (rd_rem),
        .out_quo   (rd_quo),
        .out_tag   (rd_tag)
    );

    logic                   m_valid_reg, m_drop, m_elev_nz;
    logic [30:0]            m_ray_reg, m_ray_next;
    logic signed [CS_W-1:0] m_cp_reg, m_sp_reg;

    assign m_elev_nz = (cam_elevation_reg != '0);

    always_comb
    begin
        if (rd_tag[71])
        begin
            m_ray_next = m_elev_nz ? RAY_MAX : '0;
            m_drop     = rd_tag[68] || (rd_tag[70] && m_elev_nz);
        end
        else
        begin
            m_ray_next = rd_tag[72] ? RAY_MAX : rd_quo;
            m_drop     = rd_tag[68] || ((m_ray_next != '0) && (rd_tag[70] != rd_tag[69]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= rd_valid && !m_drop && (rd_rem == rd_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ray_reg <= m_ray_next;
            m_cp_reg  <= rd_tag[67:34];
            m_sp_reg  <= rd_tag[33:0];
        end
    end

    // ray * sin pan, ray * cos pan
    logic               n_valid_reg;
    logic signed [65:0] n_px_reg, n_px_next, n_py_reg, n_py_next;

    assign n_px_next = 66'($signed({1'b0, m_ray_reg})) * 66'(m_sp_reg);
    assign n_py_next = 66'($signed({1'b0, m_ray_reg})) * 66'(m_cp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_px_reg <= n_px_next;
            n_py_reg <= n_py_next;
        end
    end

    // round to q16.16 and saturate
    logic signed [65:0] o_rx, o_ry;
    logic signed [31:0] dx_reg, dy_reg;

    assign o_rx = n_px_reg + 66'sd536870912;
    assign o_ry = n_py_reg + 66'sd536870912;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= sat32(o_rx[65:30]);
            dy_reg <= sat32(o_ry[65:30]);
        end
    end

    assign out_valid = out_valid_reg;
    assign floor_dx  = dx_reg;
    assign floor_dy  = dy_reg;

endmodule

// File: tb/sv/tb_pixel_to_floor_projection_top.sv
// tb_pixel_to_floor_projection_top: self-checking bench for the floor projection block
// holds its own fixed-point projection predictor; depends on ptf_pkg and the top level rtl

module tb_pixel_to_floor_projection_top;
    import ptf_pkg::*;

    localparam int SETTLE_CYCLES = 220;
    localparam int STALL_LIMIT   = 6000;

    typedef struct {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             mask;
    } pixel_t;

    typedef struct {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } offset_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   pixel_col = '0;
    logic [PIX_W-1:0]   pixel_row = '0;
    logic               mask_bit = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] floor_dx;
    logic signed [31:0] floor_dy;

    // shadow copy of the configuration
    logic [12:0]        img_w = 13'd640;
    logic [12:0]        img_h = 13'd480;
    logic signed [17:0] tilt = '0;
    logic signed [17:0] pan = '0;
    logic [31:0]        elevation = 32'd65536;
    logic [31:0]        focal = 32'd65536;
    logic [31:0]        sens_w = 32'd65536;
    logic [31:0]        sens_h = 32'd65536;

    pixel_t  pending_pixels[$];
    offset_t expected_offsets[$];
    pixel_t  on_wire;
    int      error_count = 0;
    bit      idling_on = 1'b1;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      long_hold = 0;
    bit      long_hold_done = 1'b0;
    int      pixels_seen = 0;
    int      quiet_cycles = 0;

    pixel_to_floor_projection_top i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint pixel_angle(input int unsigned idx, input int unsigned n,
                                           input logic [31:0] sensor, input logic [31:0] flen);
        longint s, x, y, z, nx, ny;
        longint unsigned mag, num, q;
        s = (longint'(idx) * 131072) / longint'(n) - 65536;
        mag = (s < 0) ? -s : s;
        num = 64'(sensor) * mag;
        if (flen == 0)
        begin
            q = (num != 0) ? (64'd1 << 47) : 64'd0;
        end
        else
        begin
            q = num / (64'd2 * 64'(flen));
            if (q > (64'd1 << 47))
            begin
                q = 64'd1 << 47;
            end
        end
        y = longint'(q) * 256;
        if (s < 0)
        begin
            y = -y;
        end
        x = longint'(1) << 24;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return (z + 16384) >>> 15;
    endfunction

    function automatic void rotate_angle(input longint ang, output longint c, output longint s);
        bit     flip;
        longint x, y, z, nx, ny;
        flip = 1'b0;
        x = GAIN_Q30;
        y = 0;
        while (ang > HALF_PI_Q15)
        begin
            ang = ang - PI_Q15;
            flip = !flip;
        end
        while (ang < -HALF_PI_Q15)
        begin
            ang = ang + PI_Q15;
            flip = !flip;
        end
        z = ang * 32768;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void project_pixel(input pixel_t p);
        int unsigned       w, h;
        longint            theta, phi, ct, st, cp, sp, ray;
        longint unsigned   ac, as_, mag;
        offset_t           o;
        w = (img_w > MAX_SIDE) ? MAX_SIDE : img_w;
        h = (img_h > MAX_SIDE) ? MAX_SIDE : img_h;
        if (!p.mask || w == 0 || h == 0 || p.col >= w || p.row >= h)
        begin
            return;
        end
        theta = longint'(tilt) + pixel_angle(p.row, h, sens_h, focal);
        if (theta < 0)
        begin
            return;
        end
        rotate_angle(theta, ct, st);
        if (st == 0)
        begin
            if (ct < 0 && elevation != 0)
            begin
                return;
            end
            mag = (elevation != 0) ? 64'h7FFF_FFFF : 64'd0;
        end
        else
        begin
            ac = (ct < 0) ? -ct : ct;
            as_ = (st < 0) ? -st : st;
            mag = (64'(elevation) * ac) / as_;
            if (mag > 64'h7FFF_FFFF)
            begin
                mag = 64'h7FFF_FFFF;
            end
            if (mag != 0 && ((ct < 0) != (st < 0)))
            begin
                return;
            end
        end
        ray = longint'(mag);
        phi = longint'(pan) + pixel_angle(p.col, w, sens_w, focal);
        rotate_angle(phi, cp, sp);
        o.dx = 32'(clip32((ray * sp + (longint'(1) << 29)) >>> 30));
        o.dy = 32'(clip32((ray * cp + (longint'(1) << 29)) >>> 30));
        expected_offsets.insert(expected_offsets.size(), o);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                project_pixel(on_wire);
            end
            if (in_valid && !in_ready)
            begin
                in_valid <= 1'b1;
            end
            else if (send_idle > 0)
            begin
                send_idle--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0 && idling_on && $urandom_range(0, 11) == 0)
            begin
                send_idle = $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                on_wire = pending_pixels.pop_front();
                pixel_col <= on_wire.col;
                pixel_row <= on_wire.row;
                mask_bit <= on_wire.mask;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        offset_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pixels_seen++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_offsets.size() == 0)
                begin
                    report_mismatch("unexpected transfer, floor_dx", floor_dx, 0);
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    if (floor_dx !== want.dx)
                    begin
                        report_mismatch("floor_dx", floor_dx, want.dx);
                    end
                    if (floor_dy !== want.dy)
                    begin
                        report_mismatch("floor_dy", floor_dy, want.dy);
                    end
                end
            end
            if (!long_hold_done && pixels_seen >= 320)
            begin
                long_hold_done = 1'b1;
                long_hold = 600;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ready <= 1'b0;
            end
            else if (recv_idle > 0)
            begin
                recv_idle--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                recv_idle = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_pixel_to_floor_projection_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_IMAGE_WIDTH:   img_w = val[12:0];
            REG_IMAGE_HEIGHT:  img_h = val[12:0];
            REG_CAM_TILT:      tilt = val[17:0];
            REG_CAM_PAN:       pan = val[17:0];
            REG_CAM_ELEVATION: elevation = val;
            REG_FOCAL_LEN:     focal = val;
            REG_SENSOR_WIDTH:  sens_w = val;
            default:           sens_h = val;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() > 0 || in_valid || expected_offsets.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_pixel(input int col, input int row, input bit mask);
        pixel_t p;
        p.col = PIX_W'(col);
        p.row = PIX_W'(row);
        p.mask = mask;
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    task automatic add_random_pixels(input int count);
        int unsigned w, h;
        pixel_t      p;
        w = (img_w > MAX_SIDE) ? MAX_SIDE : img_w;
        h = (img_h > MAX_SIDE) ? MAX_SIDE : img_h;
        for (int i = 0; i < count; i++)
        begin
            p.mask = ($urandom_range(0, 9) != 0);
            p.col = PIX_W'((w > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, w - 1)
                                                               : $urandom_range(0, 4095));
            p.row = PIX_W'((h > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, h - 1)
                                                               : $urandom_range(0, 4095));
            pending_pixels.insert(pending_pixels.size(), p);
        end
    endtask

    task automatic random_setup();
        case ($urandom_range(0, 4))
            0:       write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 64));
            1:       write_reg(REG_IMAGE_WIDTH, 4096);
            2:       write_reg(REG_IMAGE_WIDTH, $urandom_range(4097, 8191));
            default: write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 4))
            0:       write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 64));
            1:       write_reg(REG_IMAGE_HEIGHT, 4096);
            2:       write_reg(REG_IMAGE_HEIGHT, $urandom_range(4097, 8191));
            default: write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 4096));
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            write_reg(REG_CAM_TILT, $urandom);
        end
        else
        begin
            write_reg(REG_CAM_TILT, $urandom_range(20000, 60000));
        end
        write_reg(REG_CAM_PAN, $urandom);
        write_reg(REG_CAM_ELEVATION, ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 2000000));
        write_reg(REG_FOCAL_LEN, ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(8000, 400000));
        write_reg(REG_SENSOR_WIDTH, ($urandom_range(0, 3) == 0) ? $urandom
                                                                : $urandom_range(0, 300000));
        write_reg(REG_SENSOR_HEIGHT, ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 300000));
        end_writes();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: frame edges, outside the frame, mask clear, horizon row
        add_pixel(0, 0, 1'b1);
        add_pixel(639, 479, 1'b1);
        add_pixel(640, 300, 1'b1);
        add_pixel(100, 480, 1'b1);
        add_pixel(320, 240, 1'b1);
        add_pixel(4095, 4095, 1'b1);
        add_pixel(4095, 4095, 1'b0);
        add_pixel(200, 400, 1'b0);
        add_pixel(0, 479, 1'b1);
        add_pixel(639, 241, 1'b1);
        add_pixel(2730, 1365, 1'b1);
        add_pixel(1365, 2730, 1'b1);
        wait_idle();

        // extremes of every register
        write_reg(REG_IMAGE_WIDTH, 8191);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_CAM_TILT, 32'h1FFFF);
        write_reg(REG_CAM_PAN, 32'h20000);
        write_reg(REG_CAM_ELEVATION, 32'hFFFF_FFFF);
        write_reg(REG_FOCAL_LEN, 0);
        write_reg(REG_SENSOR_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_SENSOR_HEIGHT, 0);
        end_writes();
        add_pixel(0, 0, 1'b1);
        add_pixel(4095, 4095, 1'b1);
        add_pixel(2048, 2048, 1'b1);
        add_pixel(1, 4094, 1'b1);
        wait_idle();

        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_CAM_TILT, 32'h20000);
        write_reg(REG_CAM_ELEVATION, 0);
        write_reg(REG_FOCAL_LEN, 32'hFFFF_FFFF);
        write_reg(REG_SENSOR_HEIGHT, 32'hFFFF_FFFF);
        end_writes();
        add_pixel(0, 0, 1'b1);
        add_pixel(5, 0, 1'b1);
        wait_idle();

        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_CAM_TILT, 0);
        write_reg(REG_CAM_PAN, 32'h1FFFF);
        end_writes();
        add_pixel(0, 0, 1'b1);
        add_pixel(0, 1, 1'b1);
        wait_idle();

        // random phases, the long receiver hold falls in one of them
        for (int ph = 0; ph < 8; ph++)
        begin
            random_setup();
            add_random_pixels(95);
            wait_idle();
        end

        // calm tail with a projection that gives results
        idling_on = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 4096);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_CAM_TILT, 40000);
        write_reg(REG_CAM_PAN, 32'h3E000);
        write_reg(REG_CAM_ELEVATION, 150000);
        write_reg(REG_FOCAL_LEN, 65536);
        write_reg(REG_SENSOR_WIDTH, 80000);
        write_reg(REG_SENSOR_HEIGHT, 60000);
        end_writes();
        add_random_pixels(150);
        wait_idle();

        if (error_count == 0)
        begin
            $display("tb_pixel_to_floor_projection_top: done, clean");
        end
        else
        begin
            $display("tb_pixel_to_floor_projection_top: done, errors");
        end
        $finish;
    end

endmodule
